// ===== rtl/v3alu_pkg.sv =====
`timescale 1ns / 1ps

package v3alu_pkg;

   // Word format: signed fixed point, Q16.16 by default
   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;

   // Operation codes carried in the action field
   typedef enum logic [3:0] {
      ACT_ADD   = 4'd0,
      ACT_SUB   = 4'd1,
      ACT_NEG   = 4'd2,
      ACT_SCALE = 4'd3,
      ACT_DIV   = 4'd4,
      ACT_DOT   = 4'd5,
      ACT_CROSS = 4'd6,
      ACT_LEN   = 4'd7,
      ACT_NORM  = 4'd8
   } action_type;

   typedef struct packed {
      logic [3:0]                  action;
      logic signed [WORD_BITS-1:0] a_x;
      logic signed [WORD_BITS-1:0] a_y;
      logic signed [WORD_BITS-1:0] a_z;
      logic signed [WORD_BITS-1:0] b_x;
      logic signed [WORD_BITS-1:0] b_y;
      logic signed [WORD_BITS-1:0] b_z;
      logic signed [WORD_BITS-1:0] scalar;
   } v3alu_req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] out_x;
      logic signed [WORD_BITS-1:0] out_y;
      logic signed [WORD_BITS-1:0] out_z;
      logic signed [WORD_BITS-1:0] out_scalar;
      logic                        zero_divisor;
      logic                        saturated;
   } v3alu_rsp_type;

endpackage

// ===== rtl/vector3_alu_top.sv =====
`timescale 1ns / 1ps

// Fixed-point 3D vector unit, no state between items.
// Request channel (req_valid / req_stall / req_data): one item carries an
// action code, vectors a and b and a scalar, all signed Q16.16.
// Response channel (rsp_valid / rsp_stall / rsp_data): exactly one item per
// request, in order: vector result, scalar result, zero_divisor, saturated.
// Every action runs through the same pipeline: unpack, multiply, sum,
// pack, a square-root chain of WORD_BITS stages (one root bit each) and a
// restoring divider of WORD_BITS+FRAC_BITS stages (one quotient bit each,
// three lanes). Throughput is one item per cycle when the output is not
// stalled. When rsp_stall holds a waiting result, the whole pipeline
// freezes and req_stall rises in the same cycle; nothing is lost or
// repeated. Reset clears all valid bits, which empties the pipeline.
module vector3_alu_top (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  v3alu_pkg::v3alu_req_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output v3alu_pkg::v3alu_rsp_type rsp_data
);
   import v3alu_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int PW = 2 * W;
   localparam int SW = 2 * W + 3;
   localparam int NQ = W + F;

   typedef struct packed {
      logic [3:0]          op;
      logic [2:0]          a_neg;
      logic [2:0]          b_neg;
      logic [2:0][W-1:0]   a_mag;
      logic [2:0][W-1:0]   b_mag;
      logic [2:0][W-1:0]   a_raw;
      logic [2:0][W-1:0]   b_raw;
      logic                s_neg;
      logic [W-1:0]        s_mag;
   } s1_type;

   typedef struct packed {
      logic [3:0]          op;
      logic [2:0]          a_neg;
      logic [2:0][W-1:0]   a_mag;
      logic [2:0][W-1:0]   a_raw;
      logic [2:0][W-1:0]   b_raw;
      logic                s_neg;
      logic [W-1:0]        s_mag;
      logic [5:0]          p_neg;
      logic [5:0][PW-1:0]  p_mag;
   } s2_type;

   typedef struct packed {
      logic [3:0]          op;
      logic [2:0]          a_neg;
      logic [2:0][W-1:0]   a_mag;
      logic [2:0][W-1:0]   a_raw;
      logic                s_neg;
      logic [W-1:0]        s_mag;
      logic                sh;
      logic [2:0][SW-1:0]  r;
   } s3_type;

   typedef struct packed {
      logic [3:0]          op;
      logic [2:0][W-1:0]   o;
      logic [W-1:0]        osc;
      logic                sat;
      logic                zdiv;
      logic [2:0]          a_neg;
      logic [2:0][W-1:0]   a_mag;
      logic [W-1:0]        dvs;
      logic                dvs_neg;
   } base_type;

   typedef struct packed {
      base_type            base;
      logic [PW-1:0]       n;
      logic [W+1:0]        rem;
      logic [W-1:0]        root;
   } sq_type;

   typedef struct packed {
      base_type            base;
      logic [2:0][NQ-1:0]  dvd;
      logic [2:0][W-1:0]   rem;
      logic [2:0][NQ-1:0]  q;
   } dv_type;

   // Clamp a sign-magnitude value to the word range; top bit is the sat flag
   function automatic logic [W:0] pack_word(input logic neg, input logic [SW-1:0] mag);
      logic [SW-1:0] lim;
      logic [W-1:0]  m;
      logic          sat;
      lim = neg ? (SW'(1) << (W - 1)) : ((SW'(1) << (W - 1)) - SW'(1));
      sat = mag > lim;
      m   = sat ? lim[W-1:0] : mag[W-1:0];
      return {sat, (neg ? (~m + W'(1)) : m)};
   endfunction

   function automatic logic [SW-1:0] sext(input logic [W-1:0] v);
      return {{(SW - W){v[W-1]}}, v};
   endfunction

   logic     adv;
   logic     s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic     sq_vld_ff [0:W];
   logic     dv_vld_ff [0:NQ];
   logic     rsp_vld_ff;
   s1_type   s1_ff, s1_in;
   s2_type   s2_ff, s2_in;
   s3_type   s3_ff, s3_in;
   sq_type   sq_head;
   sq_type   sq_ff [0:W];
   sq_type   sq_in [0:W];
   dv_type   dv_head;
   dv_type   dv_ff [0:NQ];
   dv_type   dv_in [0:NQ];
   v3alu_rsp_type rsp_data_ff, rsp_data_in;

   // Freeze everything while a finished item waits at the output
   assign adv       = !rsp_vld_ff || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   // Stage 1: split operands into sign and magnitude
   always_comb begin
      logic [2:0][W-1:0] ar;
      logic [2:0][W-1:0] br;
      ar = {req_data.a_z, req_data.a_y, req_data.a_x};
      br = {req_data.b_z, req_data.b_y, req_data.b_x};
      s1_in       = '0;
      s1_in.op    = req_data.action;
      s1_in.a_raw = ar;
      s1_in.b_raw = br;
      for (int i = 0; i < 3; i++) begin
         s1_in.a_neg[i] = ar[i][W-1];
         s1_in.a_mag[i] = ar[i][W-1] ? (~ar[i] + W'(1)) : ar[i];
         s1_in.b_neg[i] = br[i][W-1];
         s1_in.b_mag[i] = br[i][W-1] ? (~br[i] + W'(1)) : br[i];
      end
      s1_in.s_neg = req_data.scalar[W-1];
      s1_in.s_mag = req_data.scalar[W-1] ? (~req_data.scalar + W'(1)) : req_data.scalar;
   end

   // Stage 2: six magnitude multipliers, operands chosen by action
   always_comb begin
      logic [5:0][W-1:0] ma;
      logic [5:0][W-1:0] mb;
      logic [5:0]        mn;
      ma = '0;
      mb = '0;
      mn = '0;
      case (s1_ff.op)
         ACT_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               ma[2*i] = s1_ff.a_mag[i];
               mb[2*i] = s1_ff.s_mag;
               mn[2*i] = s1_ff.a_neg[i] ^ s1_ff.s_neg;
            end
         end
         ACT_DOT: begin
            for (int i = 0; i < 3; i++) begin
               ma[2*i] = s1_ff.a_mag[i];
               mb[2*i] = s1_ff.b_mag[i];
               mn[2*i] = s1_ff.a_neg[i] ^ s1_ff.b_neg[i];
            end
         end
         ACT_CROSS: begin
            ma[0] = s1_ff.a_mag[1]; mb[0] = s1_ff.b_mag[2];
            mn[0] = s1_ff.a_neg[1] ^ s1_ff.b_neg[2];
            ma[1] = s1_ff.a_mag[2]; mb[1] = s1_ff.b_mag[1];
            mn[1] = s1_ff.a_neg[2] ^ s1_ff.b_neg[1];
            ma[2] = s1_ff.a_mag[2]; mb[2] = s1_ff.b_mag[0];
            mn[2] = s1_ff.a_neg[2] ^ s1_ff.b_neg[0];
            ma[3] = s1_ff.a_mag[0]; mb[3] = s1_ff.b_mag[2];
            mn[3] = s1_ff.a_neg[0] ^ s1_ff.b_neg[2];
            ma[4] = s1_ff.a_mag[0]; mb[4] = s1_ff.b_mag[1];
            mn[4] = s1_ff.a_neg[0] ^ s1_ff.b_neg[1];
            ma[5] = s1_ff.a_mag[1]; mb[5] = s1_ff.b_mag[0];
            mn[5] = s1_ff.a_neg[1] ^ s1_ff.b_neg[0];
         end
         ACT_LEN, ACT_NORM: begin
            for (int i = 0; i < 3; i++) begin
               ma[2*i] = s1_ff.a_mag[i];
               mb[2*i] = s1_ff.a_mag[i];
            end
         end
         default: begin
            ma = '0;
         end
      endcase
      s2_in       = '0;
      s2_in.op    = s1_ff.op;
      s2_in.a_neg = s1_ff.a_neg;
      s2_in.a_mag = s1_ff.a_mag;
      s2_in.a_raw = s1_ff.a_raw;
      s2_in.b_raw = s1_ff.b_raw;
      s2_in.s_neg = s1_ff.s_neg;
      s2_in.s_mag = s1_ff.s_mag;
      s2_in.p_neg = mn;
      for (int k = 0; k < 6; k++) begin
         s2_in.p_mag[k] = PW'(ma[k]) * PW'(mb[k]);
      end
   end

   // Stage 3: exact signed sums and differences
   always_comb begin
      logic [5:0][SW-1:0] sp;
      for (int k = 0; k < 6; k++) begin
         sp[k] = s2_ff.p_neg[k] ? (~{3'b000, s2_ff.p_mag[k]} + SW'(1))
                                : {3'b000, s2_ff.p_mag[k]};
      end
      s3_in       = '0;
      s3_in.op    = s2_ff.op;
      s3_in.a_neg = s2_ff.a_neg;
      s3_in.a_mag = s2_ff.a_mag;
      s3_in.a_raw = s2_ff.a_raw;
      s3_in.s_neg = s2_ff.s_neg;
      s3_in.s_mag = s2_ff.s_mag;
      case (s2_ff.op)
         ACT_ADD: begin
            for (int i = 0; i < 3; i++)
               s3_in.r[i] = sext(s2_ff.a_raw[i]) + sext(s2_ff.b_raw[i]);
         end
         ACT_SUB: begin
            for (int i = 0; i < 3; i++)
               s3_in.r[i] = sext(s2_ff.a_raw[i]) - sext(s2_ff.b_raw[i]);
         end
         ACT_NEG: begin
            for (int i = 0; i < 3; i++)
               s3_in.r[i] = SW'(0) - sext(s2_ff.a_raw[i]);
         end
         ACT_SCALE, ACT_CROSS: begin
            s3_in.sh = 1'b1;
            for (int i = 0; i < 3; i++)
               s3_in.r[i] = sp[2*i] - sp[2*i+1];
         end
         ACT_DOT, ACT_LEN, ACT_NORM: begin
            s3_in.sh   = 1'b1;
            s3_in.r[0] = sp[0] + sp[2] + sp[4];
         end
         default: begin
            s3_in.sh = 1'b0;
         end
      endcase
   end

   // Stage 4: truncate toward zero, saturate, set up root and divisor
   always_comb begin
      logic [2:0]          ng;
      logic [2:0][SW-1:0]  mg;
      logic [2:0][W:0]     pk;
      base_type            b;
      for (int i = 0; i < 3; i++) begin
         ng[i] = s3_ff.r[i][SW-1];
         mg[i] = ng[i] ? (~s3_ff.r[i] + SW'(1)) : s3_ff.r[i];
         if (s3_ff.sh)
            mg[i] = mg[i] >> F;
         pk[i] = pack_word(ng[i], mg[i]);
      end
      b       = '0;
      b.op    = s3_ff.op;
      b.a_neg = s3_ff.a_neg;
      b.a_mag = s3_ff.a_mag;
      sq_head = '0;
      case (s3_ff.op)
         ACT_ADD, ACT_SUB, ACT_NEG, ACT_SCALE, ACT_CROSS: begin
            for (int i = 0; i < 3; i++)
               b.o[i] = pk[i][W-1:0];
            b.sat = pk[0][W] | pk[1][W] | pk[2][W];
         end
         ACT_DOT: begin
            b.osc = pk[0][W-1:0];
            b.sat = pk[0][W];
         end
         ACT_LEN: begin
            sq_head.n = s3_ff.r[0][PW-1:0];
         end
         ACT_NORM: begin
            sq_head.n = s3_ff.r[0][PW-1:0];
            b.o       = s3_ff.a_raw;
         end
         ACT_DIV: begin
            b.o       = s3_ff.a_raw;
            b.dvs     = s3_ff.s_mag;
            b.dvs_neg = s3_ff.s_neg;
            b.zdiv    = s3_ff.s_mag == '0;
         end
         default: begin
            b.sat = 1'b0;
         end
      endcase
      sq_head.base = b;
   end

   // Square-root chain: one root bit per stage
   always_comb begin
      logic [W+1:0] rem2;
      logic [W+1:0] trial;
      sq_in[0] = sq_head;
      for (int k = 0; k < W; k++) begin
         rem2  = {sq_ff[k].rem[W-1:0], sq_ff[k].n[PW-1:PW-2]};
         trial = {sq_ff[k].root, 2'b01};
         sq_in[k+1]      = sq_ff[k];
         sq_in[k+1].n    = {sq_ff[k].n[PW-3:0], 2'b00};
         if (rem2 >= trial) begin
            sq_in[k+1].rem  = rem2 - trial;
            sq_in[k+1].root = {sq_ff[k].root[W-2:0], 1'b1};
         end else begin
            sq_in[k+1].rem  = rem2;
            sq_in[k+1].root = {sq_ff[k].root[W-2:0], 1'b0};
         end
      end
   end

   // Hand the length to the scalar output or to the divider
   always_comb begin
      logic [W:0] pk;
      base_type   b;
      b  = sq_ff[W].base;
      pk = pack_word(1'b0, SW'(sq_ff[W].root));
      case (b.op)
         ACT_LEN: begin
            b.osc = pk[W-1:0];
            b.sat = pk[W];
         end
         ACT_NORM: begin
            b.dvs     = sq_ff[W].root;
            b.dvs_neg = 1'b0;
            b.zdiv    = sq_ff[W].root == '0;
         end
         default: begin
            b.dvs = b.dvs;
         end
      endcase
      dv_head      = '0;
      dv_head.base = b;
      for (int i = 0; i < 3; i++)
         dv_head.dvd[i] = {b.a_mag[i], F'(0)};
   end

   // Restoring divider chain: one quotient bit per stage in each lane
   always_comb begin
      logic [W:0] rem2;
      logic [W:0] dvs1;
      logic       ge;
      dv_in[0] = dv_head;
      for (int k = 0; k < NQ; k++) begin
         dv_in[k+1] = dv_ff[k];
         dvs1 = {1'b0, dv_ff[k].base.dvs};
         for (int i = 0; i < 3; i++) begin
            rem2 = {dv_ff[k].rem[i], dv_ff[k].dvd[i][NQ-1]};
            ge   = rem2 >= dvs1;
            rem2 = ge ? (rem2 - dvs1) : rem2;
            dv_in[k+1].rem[i] = rem2[W-1:0];
            dv_in[k+1].q[i]   = {dv_ff[k].q[i][NQ-2:0], ge};
            dv_in[k+1].dvd[i] = {dv_ff[k].dvd[i][NQ-2:0], 1'b0};
         end
      end
   end

   // Output stage: pack quotients and assemble the result item
   always_comb begin
      logic [2:0][W:0] pk;
      base_type        b;
      b = dv_ff[NQ].base;
      for (int i = 0; i < 3; i++)
         pk[i] = pack_word(b.a_neg[i] ^ b.dvs_neg, SW'(dv_ff[NQ].q[i]));
      if ((b.op == ACT_DIV || b.op == ACT_NORM) && !b.zdiv) begin
         for (int i = 0; i < 3; i++)
            b.o[i] = pk[i][W-1:0];
         b.sat = pk[0][W] | pk[1][W] | pk[2][W];
      end
      rsp_data_in.out_x        = b.o[0];
      rsp_data_in.out_y        = b.o[1];
      rsp_data_in.out_z        = b.o[2];
      rsp_data_in.out_scalar   = b.osc;
      rsp_data_in.zero_divisor = b.zdiv;
      rsp_data_in.saturated    = b.sat;
   end

   // Advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         for (int k = 0; k <= W; k++)
            sq_vld_ff[k] <= 1'b0;
         for (int k = 0; k <= NQ; k++)
            dv_vld_ff[k] <= 1'b0;
      end else if (adv) begin
         s1_vld_ff    <= req_valid;
         s2_vld_ff    <= s1_vld_ff;
         s3_vld_ff    <= s2_vld_ff;
         sq_vld_ff[0] <= s3_vld_ff;
         for (int k = 0; k < W; k++)
            sq_vld_ff[k+1] <= sq_vld_ff[k];
         dv_vld_ff[0] <= sq_vld_ff[W];
         for (int k = 0; k < NQ; k++)
            dv_vld_ff[k+1] <= dv_vld_ff[k];
         rsp_vld_ff   <= dv_vld_ff[NQ];
      end
   end

   // Advance payload; hold everything while stalled
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff       <= s1_in;
         s2_ff       <= s2_in;
         s3_ff       <= s3_in;
         for (int k = 0; k <= W; k++)
            sq_ff[k] <= sq_in[k];
         for (int k = 0; k <= NQ; k++)
            dv_ff[k] <= dv_in[k];
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== verif/vector3_alu_checker.sv =====
`timescale 1ns / 1ps

module vector3_alu_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  v3alu_pkg::v3alu_req_type req_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  v3alu_pkg::v3alu_rsp_type rsp_data,
   output int                       mismatch_count,
   output int                       results_owed
);
   import v3alu_pkg::*;

   typedef logic signed [129:0] exact_type;

   v3alu_rsp_type owed_results[$];

   assign results_owed = owed_results.size();

   // Clamp an exact value to the word range, noting any clamp
   function automatic logic signed [WORD_BITS-1:0] clamp_word(input exact_type v,
                                                              inout logic sat);
      exact_type top_pos;
      exact_type top_neg;
      top_pos = (exact_type'(1) <<< (WORD_BITS - 1)) - 1;
      top_neg = -(exact_type'(1) <<< (WORD_BITS - 1));
      if (v > top_pos) begin
         sat = 1'b1;
         return top_pos[WORD_BITS-1:0];
      end
      if (v < top_neg) begin
         sat = 1'b1;
         return top_neg[WORD_BITS-1:0];
      end
      return v[WORD_BITS-1:0];
   endfunction

   // Drop fraction bits, rounding toward zero
   function automatic exact_type drop_frac(input exact_type v);
      if (v < 0)
         return -((-v) >>> FRAC_BITS);
      return v >>> FRAC_BITS;
   endfunction

   function automatic logic [63:0] root_floor(input logic [127:0] n);
      logic [63:0]  res;
      logic [127:0] cand;
      res = '0;
      for (int b = 63; b >= 0; b--) begin
         cand = {64'b0, res | (64'b1 << b)};
         if (cand * cand <= n)
            res = cand[63:0];
      end
      return res;
   endfunction

   // Work out the one result an item produces
   function automatic v3alu_rsp_type predict_result(input v3alu_req_type q);
      exact_type     a[3];
      exact_type     b[3];
      exact_type     s;
      exact_type     v[3];
      exact_type     acc;
      exact_type     len;
      logic [127:0]  sumsq;
      logic          sat;
      logic          vec;
      v3alu_rsp_type r;
      a[0] = exact_type'($signed(q.a_x));
      a[1] = exact_type'($signed(q.a_y));
      a[2] = exact_type'($signed(q.a_z));
      b[0] = exact_type'($signed(q.b_x));
      b[1] = exact_type'($signed(q.b_y));
      b[2] = exact_type'($signed(q.b_z));
      s    = exact_type'($signed(q.scalar));
      r    = '0;
      sat  = 1'b0;
      vec  = 1'b1;
      for (int i = 0; i < 3; i++) v[i] = '0;
      case (q.action)
         ACT_ADD: begin
            for (int i = 0; i < 3; i++) v[i] = a[i] + b[i];
         end
         ACT_SUB: begin
            for (int i = 0; i < 3; i++) v[i] = a[i] - b[i];
         end
         ACT_NEG: begin
            for (int i = 0; i < 3; i++) v[i] = -a[i];
         end
         ACT_SCALE: begin
            for (int i = 0; i < 3; i++) v[i] = drop_frac(a[i] * s);
         end
         ACT_DIV: begin
            if (s == 0) begin
               r.zero_divisor = 1'b1;
               for (int i = 0; i < 3; i++) v[i] = a[i];
            end else begin
               for (int i = 0; i < 3; i++) v[i] = (a[i] <<< FRAC_BITS) / s;
            end
         end
         ACT_DOT: begin
            acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
            r.out_scalar = clamp_word(drop_frac(acc), sat);
            vec = 1'b0;
         end
         ACT_CROSS: begin
            v[0] = drop_frac(a[1] * b[2] - a[2] * b[1]);
            v[1] = drop_frac(a[2] * b[0] - a[0] * b[2]);
            v[2] = drop_frac(a[0] * b[1] - a[1] * b[0]);
         end
         ACT_LEN, ACT_NORM: begin
            acc   = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
            sumsq = acc[127:0];
            len   = exact_type'({66'b0, root_floor(sumsq)});
            if (q.action == ACT_LEN) begin
               r.out_scalar = clamp_word(len, sat);
               vec = 1'b0;
            end else if (len == 0) begin
               r.zero_divisor = 1'b1;
               for (int i = 0; i < 3; i++) v[i] = a[i];
            end else begin
               for (int i = 0; i < 3; i++) v[i] = (a[i] <<< FRAC_BITS) / len;
            end
         end
         default: begin
            vec = 1'b0;
         end
      endcase
      if (vec) begin
         r.out_x = clamp_word(v[0], sat);
         r.out_y = clamp_word(v[1], sat);
         r.out_z = clamp_word(v[2], sat);
      end
      r.saturated = sat;
      return r;
   endfunction

   // Log expected results for accepted items, check delivered ones
   always @(posedge clock) begin
      v3alu_rsp_type want;
      if (reset) begin
         mismatch_count <= 0;
      end else begin
         if (req_valid && !req_stall)
            owed_results.push_back(predict_result(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (owed_results.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected result item: %p", rsp_data);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = owed_results.pop_front();
               if (want.out_x !== rsp_data.out_x || want.out_y !== rsp_data.out_y ||
                   want.out_z !== rsp_data.out_z ||
                   want.out_scalar !== rsp_data.out_scalar ||
                   want.zero_divisor !== rsp_data.zero_divisor ||
                   want.saturated !== rsp_data.saturated) begin
                  if (mismatch_count < 10)
                     $display("result mismatch: expected %p, got %p", want, rsp_data);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
   end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import v3alu_pkg::*;

   localparam int PIPE_DEPTH  = 2 * WORD_BITS + FRAC_BITS + 6;
   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_ITEMS = 1300;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   v3alu_req_type req_data = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   v3alu_rsp_type rsp_data;
   int            mismatch_count;
   int            results_owed;
   int            cycle_count = 0;
   logic          idle_enable = 1'b0;
   logic          hold_request = 1'b0;

   vector3_alu_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   vector3_alu_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Result side: random stalls, plus one long hold-off on request
   initial begin
      int   hold_left;
      logic hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            hold_left = 400;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= idle_enable && ($urandom_range(99) < 33);
         end
      end
   end

   // Offer one item and hold it until accepted; entered and left at a falling edge
   task automatic offer_item(input v3alu_req_type item);
      while (idle_enable && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   function automatic logic [WORD_BITS-1:0] pick_word();
      int sel;
      sel = $urandom_range(99);
      if (sel < 30) return $urandom;
      if (sel < 80) return WORD_BITS'($signed($urandom_range(32'h0020_0000))
                                     - $signed(32'h0010_0000));
      case ($urandom_range(5))
         0: return '0;
         1: return {1'b0, {(WORD_BITS-1){1'b1}}};
         2: return {1'b1, {(WORD_BITS-1){1'b0}}};
         3: return WORD_BITS'(1) << FRAC_BITS;
         4: return -(WORD_BITS'(1) << FRAC_BITS);
         default: return '1;
      endcase
   endfunction

   function automatic v3alu_req_type make_item(input logic [3:0] act,
                                               input logic [WORD_BITS-1:0] av,
                                               input logic [WORD_BITS-1:0] bv,
                                               input logic [WORD_BITS-1:0] sv);
      v3alu_req_type it;
      it.action = act;
      it.a_x = av; it.a_y = av; it.a_z = av;
      it.b_x = bv; it.b_y = bv; it.b_z = bv;
      it.scalar = sv;
      return it;
   endfunction

   initial begin
      logic [WORD_BITS-1:0] wmax;
      logic [WORD_BITS-1:0] wmin;
      logic [WORD_BITS-1:0] one;
      v3alu_req_type        it;
      wmax = {1'b0, {(WORD_BITS-1){1'b1}}};
      wmin = {1'b1, {(WORD_BITS-1){1'b0}}};
      one  = WORD_BITS'(1) << FRAC_BITS;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: extremes, each operation, the special cases
      offer_item(make_item(ACT_ADD, wmax, wmax, '0));
      offer_item(make_item(ACT_ADD, wmin, wmin, '0));
      offer_item(make_item(ACT_SUB, wmin, wmax, '0));
      offer_item(make_item(ACT_SUB, one, 3 * one, '0));
      offer_item(make_item(ACT_NEG, wmin, '0, '0));
      offer_item(make_item(ACT_NEG, wmax, '0, '0));
      offer_item(make_item(ACT_SCALE, wmax, '0, wmax));
      offer_item(make_item(ACT_SCALE, -3 * one, '0, one >> 1));
      offer_item(make_item(ACT_DIV, 5 * one, '0, '0));
      offer_item(make_item(ACT_DIV, 7 * one, '0, -2 * one));
      offer_item(make_item(ACT_DIV, wmax, '0, 1));
      offer_item(make_item(ACT_DOT, wmin, wmin, '0));
      offer_item(make_item(ACT_DOT, one, -2 * one, '0));
      it = make_item(ACT_CROSS, '0, '0, '0);
      it.a_x = one; it.b_y = one;
      offer_item(it);
      offer_item(make_item(ACT_CROSS, wmin, wmax, '0));
      offer_item(make_item(ACT_LEN, '0, '0, '0));
      offer_item(make_item(ACT_LEN, wmin, '0, '0));
      offer_item(make_item(ACT_NORM, '0, '0, '0));
      offer_item(make_item(ACT_NORM, 2 * one, '0, '0));
      offer_item(make_item(ACT_NORM, wmin, '0, '0));
      offer_item(make_item(4'd9, wmax, wmax, wmax));
      offer_item(make_item(4'd15, wmin, wmin, wmin));

      // Random: mostly valid actions, some unknown codes
      idle_enable <= 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 300) hold_request = 1'b1;
         if (n == 600) idle_enable <= 1'b0;
         if (n == 800) idle_enable <= 1'b1;
         if (n == 1000) begin
            req_valid <= 1'b0;
            while (results_owed != 0) @(negedge clock);
         end
         it.action = ($urandom_range(99) < 10) ? 4'($urandom_range(15, 9))
                                              : 4'($urandom_range(8));
         it.a_x = pick_word(); it.a_y = pick_word(); it.a_z = pick_word();
         it.b_x = pick_word(); it.b_y = pick_word(); it.b_z = pick_word();
         it.scalar = pick_word();
         offer_item(it);
      end
      req_valid <= 1'b0;

      // Drain, then settle
      while (results_owed != 0) @(negedge clock);
      repeat (PIPE_DEPTH + 10) @(posedge clock);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/v3alu_pkg.sv
rtl/vector3_alu_top.sv
verif/vector3_alu_checker.sv
verif/tb.sv
